/* sv/seq_reorder_rx_window_assert.svh */
// Assertion macros for the checker file.
`ifndef SEQ_REORDER_RX_WINDOW_ASSERT_SVH
`define SEQ_REORDER_RX_WINDOW_ASSERT_SVH

// Generic clocked check with explicit clock and reset.
`define SRW_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on the block clock and reset.
`define SRW_ASSERT(lbl, prop, msg) `SRW_CHECK(lbl, clock, reset, prop, msg)

`endif

/* sv/srw_pkg.sv */
`default_nettype none
package srw_pkg;

   localparam int unsigned WINDOW_SLOTS_DEFAULT = 64;
   localparam int unsigned SEQ_W       = 16;
   localparam int unsigned HANDLE_W    = 32;
   localparam int unsigned CNT_W       = 7;
   localparam int unsigned IDX_MAX_W   = 6;
   localparam int unsigned BITMAP_SPAN = 128;
   localparam int unsigned BITMAP_HALF = 64;
   localparam int unsigned SPAN_CNT_W  = 7;

   typedef enum logic [2:0] {
      CMD_STORE       = 3'd0,
      CMD_LOOKUP      = 3'd1,
      CMD_COMMIT_ONE  = 3'd2,
      CMD_COMMIT_ALL  = 3'd3,
      CMD_NACK_BITMAP = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_OUT_OF_WINDOW = 3'd1,
      ST_DUPLICATE     = 3'd2,
      ST_CONFLICT      = 3'd3,
      ST_NOT_FOUND     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_COUNT,
      BK_DRAIN,
      BK_BITMAP
   } back_state_type;

   // Decoded command; for the bitmap, sn carries base+1.
   typedef struct packed {
      cmd_type                 cmd;
      logic [SEQ_W-1:0]        sn;
      logic [HANDLE_W-1:0]     handle;
      logic [IDX_MAX_W-1:0]    idx;
   } entry_type;

   typedef struct packed {
      logic                    valid;
      status_type              status;
      logic [SEQ_W-1:0]        sn;
      logic [HANDLE_W-1:0]     handle;
      logic                    last;
      logic [BITMAP_HALF-1:0]  bitmap_low;
      logic [BITMAP_HALF-1:0]  bitmap_high;
      logic [CNT_W-1:0]        occupancy;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/srw_ram.sv */
`default_nettype none
module srw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

/* sv/srw_queue.sv */
`default_nettype none
module srw_queue
   import srw_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output      entry_type head_entry,
   output      logic      empty,
   output      logic      full
);

   // two-entry queue between front and back
   entry_type  slot_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;

   assign head_entry = slot_ff[rd_ff];
   assign empty      = (cnt_ff == 2'd0);
   assign full       = (cnt_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

/* sv/srw_front.sv */
`default_nettype none
module srw_front
   import srw_pkg::*;
#(
   parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [2:0]          cmd,
   input  wire logic [SEQ_W-1:0]    sn,
   input  wire logic [HANDLE_W-1:0] handle,
   input  wire logic [SEQ_W-1:0]    base_sn,
   output      logic                busy,
   input  wire logic                full,
   output      logic                push,
   output      entry_type           push_entry
);

   localparam int unsigned IW = $clog2(WINDOW_SLOTS);
   localparam int unsigned SH = SEQ_W + IW;
   localparam int unsigned PW = SH + SEQ_W;
   // exact floor(x / slots) for any 16-bit x
   localparam longint unsigned MULT =
      ((64'd1 << SH) + WINDOW_SLOTS - 1) / WINDOW_SLOTS;

   logic                s1_v_ff;
   logic                s2_v_ff;
   cmd_type             cmd_ff;
   logic [SEQ_W-1:0]    key_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [PW-1:0]       prod_ff;
   logic [SEQ_W-1:0]    quo_ff;
   logic                accept;
   logic                cmd_ok;
   logic [SEQ_W-1:0]    key_in;
   logic [SEQ_W-1:0]    rem;

   assign busy   = s1_v_ff | s2_v_ff;
   assign accept = start & ~busy;
   assign cmd_ok = (cmd <= CMD_NACK_BITMAP);
   assign key_in = (cmd == CMD_NACK_BITMAP) ? base_sn + 16'd1 : sn;
   assign rem    = key_ff - quo_ff * SEQ_W'(WINDOW_SLOTS);
   assign push   = s2_v_ff & ~full;

   always_comb begin
      push_entry.cmd    = cmd_ff;
      push_entry.sn     = key_ff;
      push_entry.handle = handle_ff;
      push_entry.idx    = rem[IDX_MAX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         // unused codes are taken and dropped
         s1_v_ff <= accept & cmd_ok;
         if (s1_v_ff) begin
            s2_v_ff <= 1'b1;
         end else if (push) begin
            s2_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_type'(cmd);
         key_ff    <= key_in;
         handle_ff <= handle;
         prod_ff   <= PW'(key_in) * PW'(MULT);
      end
      if (s1_v_ff) begin
         quo_ff <= prod_ff[SH +: SEQ_W];
      end
   end

endmodule
`default_nettype wire

/* sv/srw_back.sv */
`default_nettype none
module srw_back
   import srw_pkg::*;
#(
   parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      empty,
   input  wire entry_type head_entry,
   output      logic      pop,
   output      rsp_type   rsp
);

   localparam int unsigned IW = $clog2(WINDOW_SLOTS);
   localparam int unsigned RW = SEQ_W + HANDLE_W;

   back_state_type          state_ff, state_in;
   logic [SEQ_W-1:0]        head_ff, head_in;
   logic [IW-1:0]           hidx_ff, hidx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;
   entry_type               cur_ff, cur_in;
   logic [SEQ_W-1:0]        wseq_ff, wseq_in;
   logic [IW-1:0]           widx_ff, widx_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        occ_ff, occ_in;
   logic [BITMAP_SPAN-1:0]  bm_ff, bm_in;
   logic [SPAN_CNT_W-1:0]   bi_ff, bi_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    we;
   logic [IW-1:0]           raddr;
   logic [RW-1:0]           rdata;
   logic [SEQ_W-1:0]        rd_seq;
   logic [HANDLE_W-1:0]     rd_handle;
   logic [IW-1:0]           cidx;
   logic [IW-1:0]           head_nidx;
   logic [IW-1:0]           walk_nidx;
   logic                    walk_hit;
   logic [CNT_W-1:0]        n_fin;

   // slot of s+1 given slot of s, with wrap of the 16-bit space
   function automatic logic [IW-1:0] next_idx(input logic [SEQ_W-1:0] s,
                                              input logic [IW-1:0] i);
      logic [IW-1:0] r;
      if (s == {SEQ_W{1'b1}}) begin
         r = '0;
      end else if (i == IW'(WINDOW_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

   srw_ram #(
      .WIDTH (RW),
      .DEPTH (WINDOW_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (we),
      .waddr (cidx),
      .wdata ({cur_ff.sn, cur_ff.handle}),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rd_seq    = rdata[RW-1 -: SEQ_W];
   assign rd_handle = rdata[HANDLE_W-1:0];
   assign cidx      = cur_ff.idx[IW-1:0];
   assign head_nidx = next_idx(head_ff, hidx_ff);
   assign walk_nidx = next_idx(wseq_ff, widx_ff);
   assign walk_hit  = valid_ff[widx_ff] && (rd_seq == wseq_ff);
   assign n_fin     = walk_hit ? n_ff + 1'b1 : n_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      hidx_in  = hidx_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      cur_in   = cur_ff;
      wseq_in  = wseq_ff;
      widx_in  = widx_ff;
      n_in     = n_ff;
      occ_in   = occ_ff;
      bm_in    = bm_ff;
      bi_in    = bi_ff;
      rsp_in   = '0;
      pop      = 1'b0;
      we       = 1'b0;
      raddr    = hidx_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cur_in = head_entry;
               unique case (head_entry.cmd)
                  CMD_COMMIT_ONE: begin
                     state_in = BK_EXEC;
                  end
                  CMD_COMMIT_ALL: begin
                     wseq_in  = head_ff;
                     widx_in  = hidx_ff;
                     n_in     = '0;
                     state_in = BK_COUNT;
                  end
                  CMD_NACK_BITMAP: begin
                     raddr    = head_entry.idx[IW-1:0];
                     wseq_in  = head_entry.sn;
                     widx_in  = head_entry.idx[IW-1:0];
                     bi_in    = '0;
                     state_in = BK_BITMAP;
                  end
                  default: begin
                     // store and lookup
                     raddr    = head_entry.idx[IW-1:0];
                     state_in = BK_EXEC;
                  end
               endcase
            end
         end

         BK_EXEC: begin
            state_in         = BK_IDLE;
            rsp_in.valid     = 1'b1;
            rsp_in.last      = 1'b1;
            rsp_in.occupancy = cnt_ff;
            rsp_in.sn        = cur_ff.sn;
            unique case (cur_ff.cmd)
               CMD_STORE: begin
                  if ((cur_ff.sn - head_ff) >= SEQ_W'(WINDOW_SLOTS)) begin
                     rsp_in.status = ST_OUT_OF_WINDOW;
                  end else if (valid_ff[cidx]) begin
                     rsp_in.status = (rd_seq == cur_ff.sn) ? ST_DUPLICATE : ST_CONFLICT;
                  end else begin
                     we               = 1'b1;
                     valid_in[cidx]   = 1'b1;
                     cnt_in           = cnt_ff + 1'b1;
                     rsp_in.occupancy = cnt_ff + 1'b1;
                     rsp_in.status    = ST_OK;
                  end
               end
               CMD_LOOKUP: begin
                  if (valid_ff[cidx] && (rd_seq == cur_ff.sn)) begin
                     rsp_in.status = ST_OK;
                     rsp_in.handle = rd_handle;
                  end else begin
                     rsp_in.status = ST_NOT_FOUND;
                  end
               end
               default: begin
                  // commit one
                  rsp_in.sn = head_ff;
                  if (valid_ff[hidx_ff] && (rd_seq == head_ff)) begin
                     rsp_in.status     = ST_OK;
                     rsp_in.handle     = rd_handle;
                     rsp_in.occupancy  = cnt_ff - 1'b1;
                     valid_in[hidx_ff] = 1'b0;
                     cnt_in            = cnt_ff - 1'b1;
                     head_in           = head_ff + 1'b1;
                     hidx_in           = head_nidx;
                  end else begin
                     rsp_in.status = ST_NOT_FOUND;
                  end
               end
            endcase
         end

         BK_COUNT: begin
            // first pass: length of the run at head, nothing popped yet
            if (walk_hit && ((n_ff + 1'b1) < CNT_W'(WINDOW_SLOTS))) begin
               n_in    = n_ff + 1'b1;
               wseq_in = wseq_ff + 1'b1;
               widx_in = walk_nidx;
               raddr   = walk_nidx;
            end else if (n_fin == '0) begin
               rsp_in.valid     = 1'b1;
               rsp_in.status    = ST_NOT_FOUND;
               rsp_in.sn        = head_ff;
               rsp_in.last      = 1'b1;
               rsp_in.occupancy = cnt_ff;
               state_in         = BK_IDLE;
            end else begin
               n_in     = n_fin;
               occ_in   = cnt_ff - n_fin;
               state_in = BK_DRAIN;
            end
         end

         BK_DRAIN: begin
            rsp_in.valid      = 1'b1;
            rsp_in.status     = ST_OK;
            rsp_in.sn         = head_ff;
            rsp_in.handle     = rd_handle;
            rsp_in.last       = (n_ff == CNT_W'(1));
            rsp_in.occupancy  = occ_ff;
            valid_in[hidx_ff] = 1'b0;
            cnt_in            = cnt_ff - 1'b1;
            head_in           = head_ff + 1'b1;
            hidx_in           = head_nidx;
            raddr             = head_nidx;
            n_in              = n_ff - 1'b1;
            if (n_ff == CNT_W'(1)) begin
               state_in = BK_IDLE;
            end
         end

         BK_BITMAP: begin
            bm_in   = {walk_hit, bm_ff[BITMAP_SPAN-1:1]};
            wseq_in = wseq_ff + 1'b1;
            widx_in = walk_nidx;
            raddr   = walk_nidx;
            bi_in   = bi_ff + 1'b1;
            if (bi_ff == SPAN_CNT_W'(BITMAP_SPAN - 1)) begin
               rsp_in.valid       = 1'b1;
               rsp_in.status      = ST_OK;
               rsp_in.last        = 1'b1;
               rsp_in.bitmap_low  = bm_in[BITMAP_HALF-1:0];
               rsp_in.bitmap_high = bm_in[BITMAP_SPAN-1:BITMAP_HALF];
               rsp_in.occupancy   = cnt_ff;
               state_in           = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         hidx_ff      <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         hidx_ff      <= hidx_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff              <= cur_in;
      wseq_ff             <= wseq_in;
      widx_ff             <= widx_in;
      n_ff                <= n_in;
      occ_ff              <= occ_in;
      bm_ff               <= bm_in;
      bi_ff               <= bi_in;
      rsp_ff.status       <= rsp_in.status;
      rsp_ff.sn           <= rsp_in.sn;
      rsp_ff.handle       <= rsp_in.handle;
      rsp_ff.last         <= rsp_in.last;
      rsp_ff.bitmap_low   <= rsp_in.bitmap_low;
      rsp_ff.bitmap_high  <= rsp_in.bitmap_high;
      rsp_ff.occupancy    <= rsp_in.occupancy;
   end

endmodule
`default_nettype wire

/* sv/seq_reorder_rx_window.sv */
`default_nettype none
// Receive reorder window for a selective-repeat receiver. Commands are taken
// when start is high and busy is low; each result appears for one cycle with
// rsp_valid and cannot be stalled, so the user must sample every strobe.
// A front stage reduces the sequence number (or base+1 for the bitmap) to its
// slot with a constant reciprocal multiply, two register stages, then hands the
// decoded item to a two-entry queue; busy is high while the front holds an
// item, so it takes no new item until the last one is in the queue. The back
// runs one item at a time against the slot RAM (one registered read port):
// store, lookup and commit-one give one result each; commit-all picks the
// item up, makes a counting pass over the run at head (reading the slot past
// its end too, unless the whole window is ready), then gives one pop and one
// result per cycle; every result carries the occupancy after the whole drain;
// the nack bitmap reads one slot per covered sequence number. Unused command
// codes are taken and dropped with no result. Slot valid bits reset to empty
// at once; the slot contents need no clearing pass.
module seq_reorder_rx_window
   import srw_pkg::*;
#(
   parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output      logic                   busy,
   input  wire logic [2:0]             req_cmd,
   input  wire logic [SEQ_W-1:0]       req_sn,
   input  wire logic [HANDLE_W-1:0]    req_handle,
   input  wire logic [SEQ_W-1:0]       req_base_sn,
   output      logic                   rsp_valid,
   output      logic [2:0]             rsp_status,
   output      logic [SEQ_W-1:0]       rsp_sn_out,
   output      logic [HANDLE_W-1:0]    rsp_handle_out,
   output      logic                   rsp_last,
   output      logic [BITMAP_HALF-1:0] rsp_bitmap_low,
   output      logic [BITMAP_HALF-1:0] rsp_bitmap_high,
   output      logic [CNT_W-1:0]       rsp_occupancy
);

   // front -> queue -> back
   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   entry_type q_in;
   entry_type q_head;
   rsp_type   rsp;

   srw_front #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (req_cmd),
      .sn         (req_sn),
      .handle     (req_handle),
      .base_sn    (req_base_sn),
      .busy       (busy),
      .full       (q_full),
      .push       (q_push),
      .push_entry (q_in)
   );

   srw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head_entry (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   srw_back #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head_entry (q_head),
      .pop        (q_pop),
      .rsp        (rsp)
   );

   // result register fields straight out
   assign rsp_valid       = rsp.valid;
   assign rsp_status      = rsp.status;
   assign rsp_sn_out      = rsp.sn;
   assign rsp_handle_out  = rsp.handle;
   assign rsp_last        = rsp.last;
   assign rsp_bitmap_low  = rsp.bitmap_low;
   assign rsp_bitmap_high = rsp.bitmap_high;
   assign rsp_occupancy   = rsp.occupancy;

endmodule
`default_nettype wire

/* sv/srw_checker.sv */
`default_nettype none
`include "seq_reorder_rx_window_assert.svh"
module srw_checker
   import srw_pkg::*;
#(
   parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEFAULT
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic [2:0]             rsp_status,
   input wire logic [HANDLE_W-1:0]    rsp_handle_out,
   input wire logic                   rsp_last,
   input wire logic [BITMAP_HALF-1:0] rsp_bitmap_low,
   input wire logic [BITMAP_HALF-1:0] rsp_bitmap_high,
   input wire logic [CNT_W-1:0]       rsp_occupancy
);

   localparam logic [CNT_W-1:0] OCC_MAX = CNT_W'(WINDOW_SLOTS);

   logic bm_zero;
   logic is_miss;
   logic miss_clean;
   logic drain_ok;

   assign bm_zero    = (rsp_bitmap_low == '0) && (rsp_bitmap_high == '0);
   assign is_miss    = rsp_valid && (rsp_status == ST_NOT_FOUND);
   assign miss_clean = (rsp_handle_out == '0) && rsp_last;
   assign drain_ok   = (rsp_status == ST_OK) && (rsp_bitmap_low == '0);

   // a failed result carries no bitmap bits
   `SRW_ASSERT(a_bitmap_on_ok, rsp_valid && (rsp_status != ST_OK) |-> bm_zero, "bitmap on fail")

   `SRW_ASSERT(a_occ_bound, rsp_valid |-> (rsp_occupancy <= OCC_MAX), "occupancy too high")

   `SRW_ASSERT(a_miss_clean, is_miss |-> miss_clean, "miss carries handle or is not last")

   // only a drain gives non-final results, all successful pops
   `SRW_ASSERT(a_drain_ok, rsp_valid && !rsp_last |-> drain_ok, "bad non-final result")

endmodule

bind seq_reorder_rx_window srw_checker #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_srw_checker (.*);
`default_nettype wire

/* sim/seq_reorder_rx_window_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module seq_reorder_rx_window_tb;
   import srw_pkg::*;

   localparam int SLOTS = 64;

   // expected result item
   typedef struct {
      logic [2:0]  status;
      logic [15:0] sn;
      logic [31:0] handle;
      logic        last;
      logic [63:0] bm_lo;
      logic [63:0] bm_hi;
      logic [6:0]  occ;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_cmd = '0;
   logic [15:0] req_sn = '0;
   logic [31:0] req_handle = '0;
   logic [15:0] req_base_sn = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_sn_out;
   logic [31:0] rsp_handle_out;
   logic        rsp_last;
   logic [63:0] rsp_bitmap_low;
   logic [63:0] rsp_bitmap_high;
   logic [6:0]  rsp_occupancy;

   seq_reorder_rx_window u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_sn(req_sn), .req_handle(req_handle),
      .req_base_sn(req_base_sn), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_sn_out(rsp_sn_out), .rsp_handle_out(rsp_handle_out), .rsp_last(rsp_last),
      .rsp_bitmap_low(rsp_bitmap_low), .rsp_bitmap_high(rsp_bitmap_high),
      .rsp_occupancy(rsp_occupancy)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the window state
   logic        win_valid [SLOTS];
   logic [15:0] win_seq   [SLOTS];
   logic [31:0] win_handle[SLOTS];
   logic [15:0] win_head;
   logic [6:0]  win_count;

   rsp_item_type pending_rsp[$];
   int           errors = 0;
   int           burst_left = 0;

   function automatic bit win_holds(logic [15:0] s);
      return win_valid[s[5:0]] && win_seq[s[5:0]] == s;
   endfunction

   function automatic rsp_item_type mk(logic [2:0] st, logic [15:0] s, logic [31:0] h,
                                       logic l, logic [63:0] lo, logic [63:0] hi);
      rsp_item_type r;
      r.status = st; r.sn = s; r.handle = h; r.last = l;
      r.bm_lo = lo; r.bm_hi = hi; r.occ = win_count;
      return r;
   endfunction

   // Append one expected result
   function automatic void add_rsp(rsp_item_type r);
      pending_rsp = {pending_rsp, r};
   endfunction

   // Predict results of one accepted item and advance the shadow state
   task automatic predict_window(logic [2:0] cmd, logic [15:0] s, logic [31:0] h,
                                 logic [15:0] base);
      logic [15:0]  ahead;
      logic [15:0]  t;
      logic [63:0]  lo, hi;
      rsp_item_type run[$];
      int           n;
      ahead = s - win_head;
      lo = '0; hi = '0; n = 0;
      case (cmd)
         CMD_STORE: begin
            if (ahead >= SLOTS) add_rsp(mk(ST_OUT_OF_WINDOW, s, 0, 1, 0, 0));
            else if (win_valid[s[5:0]])
               add_rsp(mk(win_seq[s[5:0]] == s ? ST_DUPLICATE : ST_CONFLICT,
                          s, 0, 1, 0, 0));
            else begin
               win_valid[s[5:0]] = 1'b1; win_seq[s[5:0]] = s; win_handle[s[5:0]] = h;
               win_count++;
               add_rsp(mk(ST_OK, s, 0, 1, 0, 0));
            end
         end
         CMD_LOOKUP: begin
            if (win_holds(s)) add_rsp(mk(ST_OK, s, win_handle[s[5:0]], 1, 0, 0));
            else add_rsp(mk(ST_NOT_FOUND, s, 0, 1, 0, 0));
         end
         CMD_COMMIT_ONE: begin
            if (win_holds(win_head)) begin
               win_valid[win_head[5:0]] = 1'b0; win_count--;
               add_rsp(mk(ST_OK, win_head, win_handle[win_head[5:0]], 1, 0, 0));
               win_head++;
            end else add_rsp(mk(ST_NOT_FOUND, win_head, 0, 1, 0, 0));
         end
         CMD_COMMIT_ALL: begin
            while (n < SLOTS && win_holds(win_head)) begin
               win_valid[win_head[5:0]] = 1'b0; win_count--;
               run = {run, mk(ST_OK, win_head, win_handle[win_head[5:0]], 0, 0, 0)};
               win_head++; n++;
            end
            if (n == 0) add_rsp(mk(ST_NOT_FOUND, win_head, 0, 1, 0, 0));
            else begin
               // occupancy is the count after the whole drain
               foreach (run[k]) begin
                  run[k].occ = win_count;
                  run[k].last = (k == n - 1);
                  add_rsp(run[k]);
               end
            end
         end
         CMD_NACK_BITMAP: begin
            for (int i = 0; i < 128; i++) begin
               t = base + 16'd1 + i[15:0];
               if (win_holds(t)) begin
                  if (i < 64) lo[i] = 1'b1; else hi[i-64] = 1'b1;
               end
            end
            add_rsp(mk(ST_OK, 0, 0, 1, lo, hi));
         end
         default: ;
      endcase
   endtask

   // Send one item; bursts with random gaps, start dropped only in a gap
   task automatic send_item(logic [2:0] cmd, logic [15:0] s, logic [31:0] h,
                            logic [15:0] base);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_cmd <= cmd; req_sn <= s; req_handle <= h; req_base_sn <= base;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_window(cmd, s, h, base);
      @(negedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result status %0d sn %0d", $time, rsp_status,
                     rsp_sn_out);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_sn_out !== e.sn) begin
               $display("%0t: sn_out exp %h got %h", $time, e.sn, rsp_sn_out);
               errors++;
            end
            if (rsp_handle_out !== e.handle) begin
               $display("%0t: handle exp %h got %h", $time, e.handle, rsp_handle_out);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last exp %b got %b", $time, e.last, rsp_last);
               errors++;
            end
            if (rsp_bitmap_low !== e.bm_lo) begin
               $display("%0t: bitmap_low exp %h got %h", $time, e.bm_lo, rsp_bitmap_low);
               errors++;
            end
            if (rsp_bitmap_high !== e.bm_hi) begin
               $display("%0t: bitmap_high exp %h got %h", $time, e.bm_hi, rsp_bitmap_high);
               errors++;
            end
            if (rsp_occupancy !== e.occ) begin
               $display("%0t: occupancy exp %0d got %0d", $time, e.occ, rsp_occupancy);
               errors++;
            end
         end
      end
   end

   // Directed: window edges, every command, every error case but a conflict
   task automatic test_directed();
      send_item(CMD_COMMIT_ONE, 0, 0, 0);          // nothing at head
      send_item(CMD_COMMIT_ALL, 0, 0, 0);          // nothing ready
      send_item(CMD_STORE, 16'd64, 32'h1, 0);      // just outside window
      send_item(CMD_STORE, 16'hFFFF, 32'h2, 0);    // behind head
      send_item(CMD_STORE, 16'd0, 32'hFFFFFFFF, 0);
      send_item(CMD_STORE, 16'd63, 32'h0, 0);      // last slot in window
      send_item(CMD_STORE, 16'd0, 32'h5, 0);       // duplicate
      send_item(CMD_LOOKUP, 16'd63, 0, 0);
      send_item(CMD_LOOKUP, 16'd64, 0, 0);         // miss, same slot
      send_item(CMD_STORE, 16'd1, 32'hA5A5A5A5, 0);
      send_item(CMD_NACK_BITMAP, 0, 0, 16'hFFFF);  // covers 0..127
      send_item(CMD_NACK_BITMAP, 0, 0, 16'd62);    // 63 in low bit 0
      send_item(CMD_COMMIT_ONE, 0, 0, 0);
      send_item(CMD_COMMIT_ALL, 0, 0, 0);          // pops 1 only
      send_item(CMD_STORE, 16'd65, 32'h3, 0);      // slot 1 now free
      send_item(3'd5, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF); // unused codes
      send_item(3'd6, 0, 0, 0);
      send_item(3'd7, 0, 0, 0);
      send_item(CMD_STORE, 16'd66, 32'h4, 0);
      send_item(CMD_STORE, 16'd2, 32'h4, 0);       // conflict? slot 2 free -> ok
      send_item(CMD_STORE, 16'd66, 32'h4, 0);      // still out of window, head is 2
      send_item(CMD_COMMIT_ALL, 0, 0, 0);
   endtask

   // Fill the whole window then drain it in one go
   task automatic test_full_drain();
      logic [15:0] h0;
      h0 = win_head;
      for (int i = 0; i < SLOTS; i++) send_item(CMD_STORE, h0 + i[15:0], $urandom, 0);
      send_item(CMD_NACK_BITMAP, 0, 0, h0 - 16'd1);
      send_item(CMD_COMMIT_ALL, 0, 0, 0);
   endtask

   // Random traffic mostly near the head so the window stays busy
   task automatic test_random();
      logic [15:0] s;
      int          r;
      for (int n = 0; n < 360; n++) begin
         r = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: s = 16'($urandom);
            default: s = 16'(win_head + $urandom_range(0, 70) - 3);
         endcase
         if (r < 45) send_item(CMD_STORE, s, $urandom, 16'($urandom));
         else if (r < 60) send_item(CMD_LOOKUP, s, $urandom, 16'($urandom));
         else if (r < 75)
            send_item(CMD_COMMIT_ONE, 16'($urandom), $urandom, 16'($urandom));
         else if (r < 85)
            send_item(CMD_COMMIT_ALL, 16'($urandom), $urandom, 16'($urandom));
         else if (r < 95)
            send_item(CMD_NACK_BITMAP, 16'($urandom), $urandom,
                      $urandom_range(0, 1) ? 16'($urandom) : win_head - 16'($urandom_range(1, 70)));
         else send_item(3'($urandom_range(5, 7)), 16'($urandom), $urandom, 16'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         win_valid[i] = 1'b0; win_seq[i] = '0; win_handle[i] = '0;
      end
      win_head = '0; win_count = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);
      test_directed();
      test_full_drain();
      test_random();
      test_full_drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // Watchdog: stops a hung run; leaves room for bitmap items, drains and gaps
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
